### src/lpit_pkg.sv
// Shared types and constants for the linear-probe identifier table.
package lpit_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned ADDR_W          = 3;
  localparam int unsigned DATA_W          = 32;
  localparam logic [LEN_W-1:0] LEN_RESET  = 7'd64;

  localparam logic [1:0] REQ_LOOKUP    = 2'd0;
  localparam logic [1:0] REQ_ALLOC     = 2'd1;
  localparam logic [1:0] REQ_NEXT_UUID = 2'd2;
  localparam logic [1:0] REQ_RELEASE   = 2'd3;

  // Register index of table_length in the config space
  localparam logic REG_TABLE_LENGTH = 1'b0;

  // Command broadcast to every cell while probing
  typedef struct packed {
    logic            probe_en;
    logic            free_ok;
    logic            wr_alloc;
    logic            wr_release;
    logic [ID_W-1:0] key;
  } cell_cmd_t;

endpackage

### src/linear_probe_id_table.sv
// Top level: config register, home-slot divider, probe sequencer and cell row.
//
//  channel | ports                                      | handshake
//  in      | in_req_type, in_identifier                 | in_valid / in_stall
//  out     | out_status, out_slot, out_uuid, out_was_present | out_valid / out_stall
//  cfg     | psel penable pwrite paddr pwdata prdata pready  | APB, pready tied high
//
// One word at a time: restoring division over the 32 identifier bits for the
// home slot, a load step, then the token walks one cell per cycle through 1
// to n cells (n = effective table length), then the result is handed over,
// and the block goes back to idle before the next word is taken.
// Reset clears all entry valid bits at once.
// in_stall is high while a word is in flight or its result waits on out_stall.
module linear_probe_id_table
  import lpit_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_identifier,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_uuid,
  output logic              out_was_present,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   base_r, base_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic              status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ID_W-1:0]   uuid_r, uuid_nxt;
  logic              pres_r, pres_nxt;

  logic [31:0]       len32, n32;
  logic [LW-1:0]     n_len, n_m1;
  logic [LW:0]       div_t;
  logic [SW-1:0]     start_slot, last_slot;
  logic              cell_start;
  cell_cmd_t         cmd;
  logic [TABLE_DEPTH-1:0] tok_in, tok_fwd, tok_wrap, hit, hit_valid;
  logic              any_hit, any_present, cfg_wr;

  // effective length: 0 acts as 1, clamp at depth
  assign len32 = {{(32-LEN_W){1'b0}}, len_r};
  always_comb begin
    n32 = len32;
    if (len32 == 32'd0) n32 = 32'd1;
    if (len32 > TABLE_DEPTH) n32 = TABLE_DEPTH;
  end
  assign n_len     = n32[LW-1:0];
  assign n_m1      = n_len - LW'(1);
  assign last_slot = n_m1[SW-1:0];

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_LENGTH) ?
                  {{(DATA_W-LEN_W){1'b0}}, len_r} : '0;
  assign len_nxt = (cfg_wr && paddr[2] == REG_TABLE_LENGTH) ? pwdata[LEN_W-1:0] : len_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_uuid        = uuid_r;
  assign out_was_present = pres_r;

  assign div_t = {rem_r, id_r[bit_r]};

  assign cell_start   = (state_r == ST_LOAD);
  assign start_slot   = (req_r == REQ_NEXT_UUID) ? '0 : rem_r[SW-1:0];
  assign cmd.probe_en   = (state_r == ST_PROBE);
  assign cmd.free_ok    = (req_r == REQ_ALLOC) || (req_r == REQ_NEXT_UUID);
  assign cmd.wr_alloc   = (req_r == REQ_ALLOC);
  assign cmd.wr_release = (req_r == REQ_RELEASE);
  assign cmd.key        = (req_r == REQ_NEXT_UUID) ? base_r : id_r;

  assign any_hit     = |hit;
  assign any_present = |hit_valid;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign tok_in[gi] = |tok_wrap;
      end else begin : g_body
        assign tok_in[gi] = tok_fwd[gi-1];
      end
      lpit_cell #(
        .SLOT_BITS (SW),
        .CELL_IDX  (gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cell_start),
        .start_slot (start_slot),
        .last_slot  (last_slot),
        .tok_in     (tok_in[gi]),
        .cmd        (cmd),
        .tok_fwd    (tok_fwd[gi]),
        .tok_wrap   (tok_wrap[gi]),
        .hit        (hit[gi]),
        .hit_valid  (hit_valid[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    id_nxt     = id_r;
    base_nxt   = base_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    uuid_nxt   = uuid_r;
    pres_nxt   = pres_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          id_nxt    = in_identifier;
          rem_nxt   = '0;
          bit_nxt   = 5'd31;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle; remainder stays below n
        if (div_t >= {1'b0, n_len}) rem_nxt = LW'(div_t - {1'b0, n_len});
        else rem_nxt = div_t[LW-1:0];
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        base_nxt  = id_r - {{(ID_W-LW){1'b0}}, rem_r};
        pos_nxt   = start_slot;
        cnt_nxt   = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (any_hit) begin
          status_nxt = 1'b0;
          slot_nxt   = SLOT_W'({{(32-SW){1'b0}}, pos_r});
          pres_nxt   = any_present;
          uuid_nxt   = (req_r == REQ_NEXT_UUID) ?
                       base_r + {{(ID_W-SW){1'b0}}, pos_r} : id_r;
          state_nxt  = ST_DONE;
        end else if (cnt_r == n_m1) begin
          status_nxt = 1'b1;
          slot_nxt   = '0;
          pres_nxt   = 1'b0;
          uuid_nxt   = (req_r == REQ_NEXT_UUID) ? base_r : id_r;
          state_nxt  = ST_DONE;
        end else begin
          pos_nxt = (LW'(pos_r) == n_m1) ? '0 : pos_r + SW'(1);
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      ST_DONE: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= LEN_RESET;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    base_r   <= base_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    pos_r    <= pos_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    uuid_r   <= uuid_nxt;
    pres_r   <= pres_nxt;
  end

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> $onehot(tok_fwd | tok_wrap))
    else $error("probe token lost or duplicated");

  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one cell hit");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DIV))
    else $error("accepted word did not start division");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_slot == '0 && !out_was_present))
    else $error("failure result carries a slot");

endmodule

### src/lpit_cell.sv
// One table slot: entry storage plus one stage of the circulating probe token.
module lpit_cell
  import lpit_pkg::*;
#(
  parameter int unsigned SLOT_BITS = 6,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SLOT_BITS-1:0] start_slot,
  input  logic [SLOT_BITS-1:0] last_slot,
  input  logic                 tok_in,
  input  cell_cmd_t            cmd,
  output logic                 tok_fwd,
  output logic                 tok_wrap,
  output logic                 hit,
  output logic                 hit_valid
);

  logic            tok_r, tok_nxt;
  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic            is_last;

  assign is_last  = (last_slot == SLOT_BITS'(CELL_IDX));
  assign tok_fwd  = tok_r & ~is_last;
  assign tok_wrap = tok_r & is_last;

  // a free entry never matches the key, whatever it last held; it hits only when free_ok is set
  assign hit = cmd.probe_en & tok_r &
               ((cmd.free_ok & ~valid_r) | (valid_r & (id_r == cmd.key)));
  assign hit_valid = hit & valid_r;

  always_comb begin
    tok_nxt   = tok_r;
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (start) begin
      tok_nxt = (start_slot == SLOT_BITS'(CELL_IDX));
    end else if (cmd.probe_en) begin
      tok_nxt = tok_in;
    end
    if (hit && cmd.wr_alloc) begin
      valid_nxt = 1'b1;
      id_nxt    = cmd.key;
    end else if (hit && cmd.wr_release) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      valid_r <= valid_nxt;
    end
    id_r <= id_nxt;
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for the linear-probe identifier table.
class id_table_scoreboard;
  typedef struct packed {
    logic        status;
    logic [5:0]  slot;
    logic [31:0] uuid;
    logic        was_present;
  } result_t;

  bit          ent_valid[64];
  bit [31:0]   ent_id[64];
  bit [6:0]    table_len;
  result_t     pending[$];
  int          errors;

  function void clear();
    for (int i = 0; i < 64; i++) begin
      ent_valid[i] = 0;
      ent_id[i] = 0;
    end
    table_len = 7'd64;
    errors = 0;
  endfunction

  function int unsigned ring_len();
    int unsigned n;
    n = table_len;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function int unsigned scan(int unsigned start, int unsigned n, bit [31:0] key, bit free_ok);
    int unsigned s;
    s = start;
    for (int unsigned k = 0; k < n; k++) begin
      if ((free_ok && !ent_valid[s]) || (ent_valid[s] && ent_id[s] == key)) return s;
      s = (s + 1 == n) ? 0 : s + 1;
    end
    return n;
  endfunction

  // Update the table copy and queue the expected result word.
  function void note_request(logic [1:0] req, logic [31:0] id);
    int unsigned n, home, s;
    bit [31:0] base;
    result_t r;
    n = ring_len();
    home = id % n;
    r.status = 1;
    r.slot = 0;
    r.uuid = id;
    r.was_present = 0;
    if (req == lpit_pkg::REQ_LOOKUP || req == lpit_pkg::REQ_RELEASE) begin
      s = scan(home, n, id, 0);
      if (s < n) begin
        r.status = 0;
        r.slot = s[5:0];
        r.was_present = 1;
        if (req == lpit_pkg::REQ_RELEASE) ent_valid[s] = 0;
      end
    end else if (req == lpit_pkg::REQ_ALLOC) begin
      s = scan(home, n, id, 1);
      if (s < n) begin
        r.status = 0;
        r.slot = s[5:0];
        r.was_present = ent_valid[s];
        ent_valid[s] = 1;
        ent_id[s] = id;
      end
    end else begin
      base = id - home;
      r.uuid = base;
      s = scan(0, n, base, 1);
      if (s < n) begin
        r.status = 0;
        r.slot = s[5:0];
        r.was_present = ent_valid[s];
        r.uuid = base + s;
      end
    end
    pending.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_result(logic st, logic [5:0] sl, logic [31:0] uu, logic wp);
    result_t e;
    if (pending.size() == 0) begin
      report("unexpected word", 0, 0);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) report("status", st, e.status);
    if (sl !== e.slot) report("slot", sl, e.slot);
    if (uu !== e.uuid) report("uuid", uu, e.uuid);
    if (wp !== e.was_present) report("was_present", wp, e.was_present);
  endtask
endclass

module testbench;
  import lpit_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] in_req_type = 0;
  logic [31:0] in_identifier = 0;
  logic in_stall, out_valid, out_status, out_was_present;
  logic [5:0] out_slot;
  logic [31:0] out_uuid;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  id_table_scoreboard table_model = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  bit [31:0] recent_ids[$];

  always #1 clk = ~clk;

  linear_probe_id_table dut (.*);

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      table_model.check_result(out_status, out_slot, out_uuid, out_was_present);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any accepted word or delivered result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("linear_probe_id_table regression: fail");
      $finish;
    end
  end

  task automatic write_length(logic [6:0] len);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(4 * REG_TABLE_LENGTH); pwdata <= {25'd0, len};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    table_model.table_len = len;
  endtask

  // in_valid stays high after an accept so the next word can follow at once
  task automatic send_word(logic [1:0] req, logic [31:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_req_type <= req; in_identifier <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_model.note_request(req, id);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id(int unsigned len);
    int unsigned r;
    r = $urandom_range(9);
    if (recent_ids.size() != 0 && r < 5)
      return recent_ids[$urandom_range(recent_ids.size() - 1)];
    if (r < 8) return $urandom_range(4 * len);
    return $urandom();
  endfunction

  task automatic random_words(int count, int unsigned len);
    logic [31:0] id;
    logic [1:0] req;
    for (int i = 0; i < count; i++) begin
      id = pick_id(len);
      req = ($urandom_range(9) < 4) ? REQ_ALLOC : 2'($urandom_range(3));
      if (req == REQ_ALLOC) begin
        recent_ids.push_back(id);
        if (recent_ids.size() > 40) void'(recent_ids.pop_front());
      end
      send_word(req, id);
    end
  endtask

  initial begin
    table_model.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // directed: extremes of id, each request type, full and miss cases
    send_word(REQ_LOOKUP, 32'd5);
    send_word(REQ_RELEASE, 32'd5);
    send_word(REQ_NEXT_UUID, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC, 32'd0);
    send_word(REQ_ALLOC, 32'd64);
    send_word(REQ_LOOKUP, 32'd64);
    send_word(REQ_RELEASE, 32'd0);
    send_word(REQ_LOOKUP, 32'd64);
    send_word(REQ_LOOKUP, 32'd0);
    send_word(REQ_NEXT_UUID, 32'd130);
    send_word(REQ_NEXT_UUID, 32'd0);
    drain();
    write_length(7'd0);
    send_word(REQ_ALLOC, 32'd7);
    send_word(REQ_ALLOC, 32'd8);
    send_word(REQ_NEXT_UUID, 32'd9);
    send_word(REQ_NEXT_UUID, 32'd7);
    send_word(REQ_RELEASE, 32'd7);
    send_word(REQ_NEXT_UUID, 32'hAAAA_5555);
    drain();
    write_length(7'd127);
    send_word(REQ_LOOKUP, 32'h5555_AAAA);
    drain();
    // random phases over several lengths and idle mixes
    write_length(7'd5);
    random_words(80, 5);
    send_idle_pct = 81;
    random_words(50, 5);
    drain();
    write_length(7'd64);
    send_idle_pct = 0; recv_stall_pct = 81;
    random_words(80, 64);
    send_idle_pct = 11; recv_stall_pct = 11;
    random_words(60, 64);
    drain();
    write_length(7'd1);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_words(40, 1);
    drain();
    write_length(7'd13);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_words(10, 13);
    join
    random_words(100, 13);
    recv_stall_pct = 30; send_idle_pct = 30;
    random_words(60, 13);
    drain();
    if (table_model.errors == 0 && table_model.pending.size() == 0)
      $display("linear_probe_id_table regression: pass");
    else
      $display("linear_probe_id_table regression: fail");
    $finish;
  end
endmodule
